FILE: hdl/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

  localparam int STORE_BYTES     = 256;
  localparam int MAX_BITS_PER_OP = 32;
  localparam int LENGTH_RESET    = 256;
  localparam int BYTE_BITS       = 8;

  localparam int OP_W   = 2;
  localparam int LEN_W  = 9;
  localparam int CNT_W  = 6;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 11;
  localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CAP_W  = $clog2(BYTE_BITS * STORE_BYTES + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE      = 2'd0,
    OP_READ       = 2'd1,
    OP_SEEK_READ  = 2'd2,
    OP_SEEK_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic fetch;
    logic apply;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic more;
  } status_t;

endpackage

FILE: hdl/brb_ctrl.sv
`timescale 1ns / 1ps

module brb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  brb_pkg::status_t status,
  output brb_pkg::cmd_t    cmd
);

  brb_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brb_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      brb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = brb_pkg::ST_FETCH;
        end
      end
      brb_pkg::ST_FETCH: begin
        if (status.more) begin
          cmd.fetch  = 1'b1;
          state_next = brb_pkg::ST_APPLY;
        end else begin
          state_next = brb_pkg::ST_FINISH;
        end
      end
      brb_pkg::ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = brb_pkg::ST_FETCH;
      end
      brb_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = brb_pkg::ST_IDLE;
        end
      end
      default: state_next = brb_pkg::ST_IDLE;
    endcase
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

FILE: hdl/brb_datapath.sv
`timescale 1ns / 1ps

module brb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [brb_pkg::LEN_W-1:0]     cfg_wdata,
  input  logic [brb_pkg::OP_W-1:0]      opcode,
  input  logic [brb_pkg::CNT_W-1:0]     bit_count,
  input  logic [brb_pkg::VAL_W-1:0]     write_value,
  input  logic [brb_pkg::POS_W-1:0]     position,
  input  brb_pkg::cmd_t                 cmd,
  output brb_pkg::status_t              status,
  output logic [brb_pkg::VAL_W-1:0]     read_value,
  output logic [brb_pkg::CNT_W-1:0]     bits_got,
  output logic [brb_pkg::POS_W-1:0]     remaining_bits,
  output logic [brb_pkg::POS_W-1:0]     read_position,
  output logic [brb_pkg::POS_W-1:0]     write_position,
  output logic                          seek_error
);

  localparam int POS_W  = brb_pkg::POS_W;
  localparam int CAP_W  = brb_pkg::CAP_W;
  localparam int CNT_W  = brb_pkg::CNT_W;
  localparam int ADDR_W = brb_pkg::ADDR_W;

  function automatic logic [CAP_W-1:0] rem_of(input logic [POS_W-1:0] w,
                                              input logic [POS_W-1:0] r,
                                              input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] wx;
    logic [CAP_W-1:0] rx;
    wx = CAP_W'(w);
    rx = CAP_W'(r);
    if (w >= r) begin
      return wx - rx;
    end else begin
      return c - (rx - wx);
    end
  endfunction

  // configuration and positions
  logic [brb_pkg::LEN_W-1:0]  length;
  logic [POS_W-1:0]           rpos;
  logic [POS_W-1:0]           wpos;

  // latched transaction
  brb_pkg::op_t               op;
  logic [CNT_W-1:0]           cnt_left;
  logic [brb_pkg::VAL_W-1:0]  wval;
  logic [POS_W-1:0]           seek_pos;
  logic [brb_pkg::VAL_W-1:0]  rval;
  logic [CNT_W-1:0]           got;

  // byte store
  logic [7:0]                 mem [brb_pkg::STORE_BYTES];
  logic [brb_pkg::STORE_BYTES-1:0] vld;
  logic [7:0]                 rdata;
  logic                       rvld;

  logic [CAP_W-1:0]           eff_len;
  logic [CAP_W-1:0]           cap;
  logic [CNT_W-1:0]           cnt_in;
  logic                       is_write;
  logic                       is_read;
  logic [POS_W-1:0]           cur;
  logic [2:0]                 off;
  logic [3:0]                 room;
  logic [3:0]                 n;
  logic [2:0]                 sh;
  logic [7:0]                 mask;
  logic [7:0]                 chunk;
  logic [7:0]                 old_byte;
  logic [7:0]                 new_byte;
  logic [7:0]                 rbits;
  logic [CAP_W-1:0]           rem_now;
  logic [CAP_W-1:0]           adv;
  logic [POS_W-1:0]           next_pos;
  logic [ADDR_W-1:0]          addr;
  logic                       err;
  logic [POS_W-1:0]           rpos_f;
  logic [POS_W-1:0]           wpos_f;
  logic [CAP_W-1:0]           rem_f;

  always_comb begin
    if (length == '0) begin
      eff_len = CAP_W'(1);
    end else if (int'(length) > brb_pkg::STORE_BYTES) begin
      eff_len = CAP_W'(brb_pkg::STORE_BYTES);
    end else begin
      eff_len = CAP_W'(length);
    end
    cap = eff_len << 3;

    if (bit_count > CNT_W'(brb_pkg::MAX_BITS_PER_OP)) begin
      cnt_in = CNT_W'(brb_pkg::MAX_BITS_PER_OP);
    end else begin
      cnt_in = bit_count;
    end

    is_write = (op == brb_pkg::OP_WRITE);
    is_read  = (op == brb_pkg::OP_READ);
    cur      = is_write ? wpos : rpos;
    off      = cur[2:0];
    room     = 4'(brb_pkg::BYTE_BITS) - {1'b0, off};
    rem_now  = rem_of(wpos, rpos, cap);

    // bits handled in this byte: limited by byte end, count and unread data
    n = room;
    if (cnt_left < CNT_W'(n)) begin
      n = cnt_left[3:0];
    end
    if (is_read && (rem_now < CAP_W'(n))) begin
      n = rem_now[3:0];
    end

    status.more = (is_write || is_read) && (cnt_left != '0) &&
                  (is_write || (rem_now != '0));

    sh       = 3'(room - n);
    mask     = 8'((9'd1 << n) - 9'd1);
    chunk    = 8'(wval >> (cnt_left - CNT_W'(n))) & mask;
    old_byte = rvld ? rdata : 8'd0;
    // first bit of a byte clears it
    new_byte = ((off == 3'd0) ? 8'd0 : old_byte) | 8'(chunk << sh);
    rbits    = (old_byte >> sh) & mask;

    adv      = CAP_W'(cur) + CAP_W'(n);
    next_pos = (adv >= cap) ? '0 : POS_W'(adv);
    addr     = ADDR_W'(cur >> 3);

    err    = (op == brb_pkg::OP_SEEK_READ || op == brb_pkg::OP_SEEK_WRITE) &&
             (int'(seek_pos) >= int'(cap));
    rpos_f = (op == brb_pkg::OP_SEEK_READ && !err) ? seek_pos : rpos;
    wpos_f = (op == brb_pkg::OP_SEEK_WRITE && !err) ? seek_pos : wpos;
    rem_f  = rem_of(wpos_f, rpos_f, cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= brb_pkg::LEN_W'(brb_pkg::LENGTH_RESET);
      rpos   <= '0;
      wpos   <= '0;
      vld    <= '0;
      rvld   <= 1'b0;
    end else begin
      if (cfg_we) begin
        length <= cfg_wdata;
        rpos   <= '0;
        wpos   <= '0;
      end else if (cmd.apply) begin
        if (is_write) begin
          wpos <= next_pos;
        end else begin
          rpos <= next_pos;
        end
      end else if (cmd.finish) begin
        rpos <= rpos_f;
        wpos <= wpos_f;
      end
      if (cmd.fetch) begin
        rvld <= vld[addr];
      end
      if (cmd.apply && is_write) begin
        vld[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      rdata <= mem[addr];
    end
    if (cmd.apply && is_write) begin
      mem[addr] <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op       <= brb_pkg::op_t'(opcode);
      cnt_left <= cnt_in;
      wval     <= write_value;
      seek_pos <= position;
      rval     <= '0;
      got      <= '0;
    end else if (cmd.apply) begin
      cnt_left <= cnt_left - CNT_W'(n);
      if (is_read) begin
        rval <= (rval << n) | brb_pkg::VAL_W'(rbits);
        got  <= got + CNT_W'(n);
      end
    end
    if (cmd.finish) begin
      read_value     <= rval;
      bits_got       <= got;
      remaining_bits <= POS_W'(rem_f);
      read_position  <= rpos_f;
      write_position <= wpos_f;
      seek_error     <= err;
    end
  end

endmodule

FILE: hdl/bit_ring_buffer.sv
`timescale 1ns / 1ps

// Bit-addressed circular buffer over a 256-byte store, MSB first within each
// byte. Each transaction (write bits, read bits, seek read, seek write) gives
// one result with the bits read, the bit count delivered, the unread bit count
// and both positions. The store is worked a byte at a time (read, then, for a
// write, modify and write back) through a single memory port. An accepted op
// steps through FETCH and APPLY for each byte it touches (seeks and zero-count
// ops touch none), then FINISH registers the result and returns to IDLE.
// One op is in flight at a time; a finished result waits in the output
// register while the next op is accepted, and an op holds its result back
// while the output register is still full. Writing cfg_wdata with cfg_we sets
// the length in bytes and clears both positions; write it only while no op is
// pending. Stored bytes read as zero until first written after reset.
module bit_ring_buffer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [brb_pkg::LEN_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [brb_pkg::OP_W-1:0]  opcode,
  input  logic [brb_pkg::CNT_W-1:0] bit_count,
  input  logic [brb_pkg::VAL_W-1:0] write_value,
  input  logic [brb_pkg::POS_W-1:0] position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [brb_pkg::VAL_W-1:0] read_value,
  output logic [brb_pkg::CNT_W-1:0] bits_got,
  output logic [brb_pkg::POS_W-1:0] remaining_bits,
  output logic [brb_pkg::POS_W-1:0] read_position,
  output logic [brb_pkg::POS_W-1:0] write_position,
  output logic                      seek_error
);

  brb_pkg::cmd_t    cmd;
  brb_pkg::status_t status;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  brb_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .opcode         (opcode),
    .bit_count      (bit_count),
    .write_value    (write_value),
    .position       (position),
    .cmd            (cmd),
    .status         (status),
    .read_value     (read_value),
    .bits_got       (bits_got),
    .remaining_bits (remaining_bits),
    .read_position  (read_position),
    .write_position (write_position),
    .seek_error     (seek_error)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int OP_W            = brb_pkg::OP_W;
  localparam int LEN_W           = brb_pkg::LEN_W;
  localparam int CNT_W           = brb_pkg::CNT_W;
  localparam int VAL_W           = brb_pkg::VAL_W;
  localparam int POS_W           = brb_pkg::POS_W;
  localparam int STORE_BYTES     = brb_pkg::STORE_BYTES;
  localparam int MAX_BITS_PER_OP = brb_pkg::MAX_BITS_PER_OP;
  localparam int LENGTH_RESET    = brb_pkg::LENGTH_RESET;
  localparam int BYTE_BITS       = brb_pkg::BYTE_BITS;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 11;

  typedef struct packed {
    brb_pkg::op_t      op;
    logic [CNT_W-1:0]  cnt;
    logic [VAL_W-1:0]  wval;
    logic [POS_W-1:0]  pos;
  } ring_op_t;

  typedef struct packed {
    logic [VAL_W-1:0]  read_value;
    logic [CNT_W-1:0]  bits_got;
    logic [POS_W-1:0]  remaining_bits;
    logic [POS_W-1:0]  read_position;
    logic [POS_W-1:0]  write_position;
    logic              seek_error;
  } ring_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   opcode = '0;
  logic [CNT_W-1:0]  bit_count = '0;
  logic [VAL_W-1:0]  write_value = '0;
  logic [POS_W-1:0]  position = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [VAL_W-1:0]  read_value;
  logic [CNT_W-1:0]  bits_got;
  logic [POS_W-1:0]  remaining_bits;
  logic [POS_W-1:0]  read_position;
  logic [POS_W-1:0]  write_position;
  logic              seek_error;

  ring_op_t      queued_ops[$];
  ring_result_t  due_results[$];
  int            fail_count = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  // Shadow state of the buffer
  logic [7:0]        ring_store [STORE_BYTES];
  int                rd_bit = 0;
  int                wr_bit = 0;
  int                ring_len = LENGTH_RESET;
  int                phase_len [PHASES];

  bit_ring_buffer DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .bit_count      (bit_count),
    .write_value    (write_value),
    .position       (position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_value     (read_value),
    .bits_got       (bits_got),
    .remaining_bits (remaining_bits),
    .read_position  (read_position),
    .write_position (write_position),
    .seek_error     (seek_error)
  );

  always #5 clk = ~clk;

  function automatic int ring_cap();
    int eff;
    eff = (ring_len == 0) ? 1 : (ring_len > STORE_BYTES) ? STORE_BYTES : ring_len;
    return eff * BYTE_BITS;
  endfunction

  function automatic ring_result_t ring_apply(brb_pkg::op_t op, logic [CNT_W-1:0] cnt_in,
                                              logic [VAL_W-1:0] wval,
                                              logic [POS_W-1:0] pos);
    ring_result_t r;
    int cap;
    int cnt;
    int idx;
    int sh;
    int i;
    logic [7:0] b;
    r = '0;
    cap = ring_cap();
    cnt = (cnt_in > MAX_BITS_PER_OP) ? MAX_BITS_PER_OP : int'(cnt_in);
    case (op)
      brb_pkg::OP_WRITE: begin
        for (i = cnt; i > 0; i--) begin
          idx = (wr_bit / BYTE_BITS) % STORE_BYTES;
          sh = (BYTE_BITS - 1) - (wr_bit % BYTE_BITS);
          // first bit of a byte clears it, later bits are ORed in
          b = (sh == BYTE_BITS - 1) ? 8'h00 : ring_store[idx];
          b[sh] = b[sh] | wval[i-1];
          ring_store[idx] = b;
          wr_bit++;
          if (wr_bit >= cap) wr_bit = 0;
        end
      end
      brb_pkg::OP_READ: begin
        while (r.bits_got < cnt && rd_bit != wr_bit) begin
          idx = (rd_bit / BYTE_BITS) % STORE_BYTES;
          sh = (BYTE_BITS - 1) - (rd_bit % BYTE_BITS);
          r.read_value = {r.read_value[VAL_W-2:0], ring_store[idx][sh]};
          r.bits_got++;
          rd_bit++;
          if (rd_bit >= cap) rd_bit = 0;
        end
      end
      default: begin
        if (int'(pos) >= cap) r.seek_error = 1'b1;
        else if (op == brb_pkg::OP_SEEK_READ) rd_bit = int'(pos);
        else wr_bit = int'(pos);
      end
    endcase
    r.remaining_bits = POS_W'((wr_bit >= rd_bit) ? wr_bit - rd_bit
                                                 : cap - (rd_bit - wr_bit));
    r.read_position  = POS_W'(rd_bit);
    r.write_position = POS_W'(wr_bit);
    return r;
  endfunction

  // Driver: hold the payload until the transaction is taken
  always @(posedge clk) begin : drive_proc
    ring_op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(ring_apply(brb_pkg::op_t'(opcode), bit_count, write_value,
                                         position));
        void'(queued_ops.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (queued_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = queued_ops[0];
          in_valid    <= 1'b1;
          opcode      <= nxt.op;
          bit_count   <= nxt.cnt;
          write_value <= nxt.wval;
          position    <= nxt.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor
  always @(posedge clk) begin : check_proc
    ring_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("read_value", want.read_value, read_value);
          check_field("bits_got", VAL_W'(want.bits_got), VAL_W'(bits_got));
          check_field("remaining_bits", VAL_W'(want.remaining_bits),
                      VAL_W'(remaining_bits));
          check_field("read_position", VAL_W'(want.read_position),
                      VAL_W'(read_position));
          check_field("write_position", VAL_W'(want.write_position),
                      VAL_W'(write_position));
          check_field("seek_error", VAL_W'(want.seek_error), VAL_W'(seek_error));
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_op(brb_pkg::op_t op, int cnt, logic [VAL_W-1:0] wval, int pos);
    ring_op_t item;
    item.op   = op;
    item.cnt  = CNT_W'(cnt);
    item.wval = wval;
    item.pos  = POS_W'(pos);
    queued_ops.push_back(item);
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 12) return $urandom_range(33, 63);
    if (r < 20) return MAX_BITS_PER_OP;
    return $urandom_range(1, 31);
  endfunction

  function automatic int pick_pos(int cap);
    if ($urandom_range(0, 99) < 70) return $urandom_range(0, cap - 1);
    return $urandom_range(0, 2047);
  endfunction

  task automatic fill_random(int n);
    int made;
    int cap;
    int burst;
    made = 0;
    cap = ring_cap();
    while (made < n) begin
      if ($urandom_range(0, 99) < 70) begin
        // burst of writes, then one more read than there were writes
        burst = $urandom_range(1, 4);
        repeat (burst) queue_op(brb_pkg::OP_WRITE, pick_count(), $urandom(),
                                $urandom_range(0, 2047));
        repeat (burst + 1) queue_op(brb_pkg::OP_READ, pick_count(), $urandom(),
                                    $urandom_range(0, 2047));
        made += 2 * burst + 1;
      end else begin
        queue_op(brb_pkg::op_t'(OP_W'($urandom_range(0, 3))), pick_count(), $urandom(),
                 pick_pos(cap));
        made++;
      end
    end
  endtask

  task automatic drain();
    while (queued_ops.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_length(int len);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LEN_W'(len);
    @(posedge clk);
    cfg_we    <= 1'b0;
    ring_len = len;
    rd_bit = 0;
    wr_bit = 0;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  initial begin : stimulus
    int p;
    for (p = 0; p < STORE_BYTES; p++) ring_store[p] = 8'h00;
    phase_len = '{256, 1, 0, 511, 3, 257, 5, 2, 40, 0, 256};
    phase_len[9] = $urandom_range(1, STORE_BYTES);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: full-size buffer
    queue_op(brb_pkg::OP_READ, 8, 32'h0, 0);
    queue_op(brb_pkg::OP_WRITE, 0, 32'hFFFF_FFFF, 0);
    queue_op(brb_pkg::OP_WRITE, 32, 32'hFFFF_FFFF, 0);
    queue_op(brb_pkg::OP_WRITE, 63, 32'h1234_5678, 2047);
    queue_op(brb_pkg::OP_WRITE, 1, 32'h0, 0);
    queue_op(brb_pkg::OP_READ, 0, 32'h0, 0);
    queue_op(brb_pkg::OP_READ, 63, 32'h0, 0);
    queue_op(brb_pkg::OP_READ, 32, 32'h0, 0);
    queue_op(brb_pkg::OP_READ, 5, 32'h0, 0);
    queue_op(brb_pkg::OP_SEEK_WRITE, 0, 32'h0, 2047);
    queue_op(brb_pkg::OP_SEEK_READ, 0, 32'h0, 2040);
    queue_op(brb_pkg::OP_WRITE, 16, 32'h0000_A5C3, 0);
    queue_op(brb_pkg::OP_READ, 20, 32'h0, 0);
    queue_op(brb_pkg::OP_SEEK_READ, 0, 32'h0, 0);
    queue_op(brb_pkg::OP_SEEK_WRITE, 0, 32'h0, 0);

    // Directed: one-byte buffer, overrun and out-of-range seeks
    set_length(1);
    queue_op(brb_pkg::OP_WRITE, 5, 32'h0000_001F, 0);
    queue_op(brb_pkg::OP_WRITE, 12, 32'h0000_0ABC, 0);
    queue_op(brb_pkg::OP_READ, 32, 32'h0, 0);
    queue_op(brb_pkg::OP_SEEK_READ, 0, 32'h0, 8);
    queue_op(brb_pkg::OP_SEEK_WRITE, 0, 32'h0, 2047);
    queue_op(brb_pkg::OP_SEEK_READ, 0, 32'h0, 7);
    queue_op(brb_pkg::OP_SEEK_WRITE, 0, 32'h0, 7);
    queue_op(brb_pkg::OP_READ, 3, 32'h0, 0);
    queue_op(brb_pkg::OP_WRITE, 7, 32'h0, 0);

    for (p = 0; p < PHASES; p++) begin
      set_length(phase_len[p]);
      set_idle(p % 4);
      fill_random(100);
    end

    drain();
    repeat (20) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/brb_pkg.sv
hdl/brb_ctrl.sv
hdl/brb_datapath.sv
hdl/bit_ring_buffer.sv
tb/tb.sv
